// ===== design/sat_pkg.sv =====
// ----------------------------------------------------------------------------
// sat_pkg
// Shared types and constants for the segment address translation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package sat_pkg;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK          = 2'd0;
  localparam status_t ST_BOUNDS      = 2'd1;
  localparam status_t ST_NOT_PRESENT = 2'd2;

  typedef logic [2:0] seg_idx_t;

  localparam seg_idx_t IDX_FS = 3'd4;
  localparam seg_idx_t IDX_GS = 3'd5;

  localparam logic [63:0] WORD_MAX = 64'h0000_0000_0000_ffff;

  // Limit-check flags handed from the compare stage to the status decision
  typedef struct packed {
    logic present;
    logic expand_down;
    logic check;
    logic gran;
    logic off_gt_limit;
    logic off_gt_word;
  } sat_chk_t;

endpackage

`default_nettype wire

// ===== design/sat_in_if.sv =====
// ----------------------------------------------------------------------------
// sat_in_if
// Access channel: one segmented access per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface sat_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  seg_index;
  logic        real_or_v86;
  logic        long_mode_active;
  logic        code_seg_long;
  logic        hidden_valid;
  logic [15:0] seg_selector;
  logic [63:0] seg_base;
  logic [31:0] seg_limit;
  logic        seg_present;
  logic [3:0]  seg_type;
  logic        seg_granularity;
  logic [63:0] offset_addr;

  modport source (
    output valid, seg_index, real_or_v86, long_mode_active, code_seg_long,
           hidden_valid, seg_selector, seg_base, seg_limit, seg_present,
           seg_type, seg_granularity, offset_addr,
    input  ready
  );

  modport sink (
    input  valid, seg_index, real_or_v86, long_mode_active, code_seg_long,
           hidden_valid, seg_selector, seg_base, seg_limit, seg_present,
           seg_type, seg_granularity, offset_addr,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/sat_out_if.sv =====
// ----------------------------------------------------------------------------
// sat_out_if
// Result channel: flat address and status per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface sat_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] flat_addr;
  logic [1:0]  status;

  modport source (
    output valid, flat_addr, status,
    input  ready
  );

  modport sink (
    input  valid, flat_addr, status,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/segment_address_translate_core.sv =====
// Throughput: one access per cycle; stalls back-pressure through the three
//   stage registers without loss or repetition.
// The 64-bit base add is split over the second and third stage (32 bits each).
// Reset (rst_n low, synchronous) clears the stage valid bits only.
// ----------------------------------------------------------------------------
// segment_address_translate_core
// Segmented-to-flat address translation with limit and present checks.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_address_translate_core (
  input  wire       clk,
  input  wire       rst_n,
  sat_in_if.sink    in_chan,
  sat_out_if.source out_chan
);
  import sat_pkg::*;

  // Stage 1: registered access
  logic        s1_valid_r;
  logic [2:0]  s1_idx_r;
  logic        s1_rv86_r;
  logic        s1_lma_r;
  logic        s1_cslong_r;
  logic        s1_hvalid_r;
  logic [15:0] s1_sel_r;
  logic [63:0] s1_base_r;
  logic [31:0] s1_limit_r;
  logic        s1_present_r;
  logic [3:0]  s1_type_r;
  logic        s1_gran_r;
  logic [63:0] s1_off_r;

  // Stage 2: low sums and compares
  logic        s2_valid_r;
  logic        s2_rv86_r;
  logic        s2_mode64_r;
  logic        s2_fsgs_r;
  logic [31:0] s2_base_hi_r;
  logic [63:0] s2_off_r;
  logic [32:0] s2_lo_sum_r;
  logic [31:0] s2_rv86_sum_r;
  sat_chk_t    s2_chk_r;

  // Stage 3: output register
  logic        s3_valid_r;
  logic [63:0] s3_flat_r;
  status_t     s3_status_r;

  logic adv1, adv2, adv3;

  assign adv3 = !s3_valid_r || out_chan.ready;
  assign adv2 = !s2_valid_r || adv3;
  assign adv1 = !s1_valid_r || adv2;
  assign in_chan.ready = adv1;

  // Stage 2 combinational
  logic        mode64_nxt;
  logic        fsgs_nxt;
  logic [31:0] rv86_base;
  logic [31:0] rv86_sum_nxt;
  logic [32:0] lo_sum_nxt;
  sat_chk_t    chk_nxt;

  always_comb begin
    mode64_nxt   = s1_lma_r && s1_cslong_r;
    fsgs_nxt     = (s1_idx_r == IDX_FS) || (s1_idx_r == IDX_GS);
    rv86_base    = s1_hvalid_r ? s1_base_r[31:0] : {12'd0, s1_sel_r, 4'd0};
    rv86_sum_nxt = rv86_base + {16'd0, s1_off_r[15:0]};
    lo_sum_nxt   = {1'b0, s1_base_r[31:0]} + {1'b0, s1_off_r[31:0]};
    chk_nxt.present      = s1_present_r;
    chk_nxt.expand_down  = (s1_type_r[3:2] == 2'b01);
    chk_nxt.check        = !mode64_nxt;
    chk_nxt.gran         = s1_gran_r;
    chk_nxt.off_gt_limit = (|s1_off_r[63:32]) || (s1_off_r[31:0] > s1_limit_r);
    chk_nxt.off_gt_word  = (s1_off_r > WORD_MAX);
  end

  // Stage 3 combinational
  logic [31:0] hi_sum;
  status_t     chk_status;
  status_t     status_nxt;
  logic [63:0] flat_nxt;
  logic [63:0] addr_sel;

  sat_status u_status (
    .chk    (s2_chk_r),
    .status (chk_status)
  );

  always_comb begin
    hi_sum = s2_base_hi_r + s2_off_r[63:32] + {31'd0, s2_lo_sum_r[32]};
    if (s2_rv86_r) begin
      addr_sel   = {32'd0, s2_rv86_sum_r};
      status_nxt = ST_OK;
    end else begin
      status_nxt = chk_status;
      if (s2_mode64_r) begin
        addr_sel = s2_fsgs_r ? {hi_sum, s2_lo_sum_r[31:0]} : s2_off_r;
      end else begin
        addr_sel = {32'd0, s2_lo_sum_r[31:0]};
      end
    end
    // drop the address on any failure
    flat_nxt = (status_nxt == ST_OK) ? addr_sel : 64'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (adv1) s1_valid_r <= in_chan.valid;
      if (adv2) s2_valid_r <= s1_valid_r;
      if (adv3) s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_idx_r     <= in_chan.seg_index;
      s1_rv86_r    <= in_chan.real_or_v86;
      s1_lma_r     <= in_chan.long_mode_active;
      s1_cslong_r  <= in_chan.code_seg_long;
      s1_hvalid_r  <= in_chan.hidden_valid;
      s1_sel_r     <= in_chan.seg_selector;
      s1_base_r    <= in_chan.seg_base;
      s1_limit_r   <= in_chan.seg_limit;
      s1_present_r <= in_chan.seg_present;
      s1_type_r    <= in_chan.seg_type;
      s1_gran_r    <= in_chan.seg_granularity;
      s1_off_r     <= in_chan.offset_addr;
    end
    if (adv2) begin
      s2_rv86_r     <= s1_rv86_r;
      s2_mode64_r   <= mode64_nxt;
      s2_fsgs_r     <= fsgs_nxt;
      s2_base_hi_r  <= s1_base_r[63:32];
      s2_off_r      <= s1_off_r;
      s2_lo_sum_r   <= lo_sum_nxt;
      s2_rv86_sum_r <= rv86_sum_nxt;
      s2_chk_r      <= chk_nxt;
    end
    if (adv3) begin
      s3_flat_r   <= flat_nxt;
      s3_status_r <= status_nxt;
    end
  end

  assign out_chan.valid     = s3_valid_r;
  assign out_chan.flat_addr = s3_flat_r;
  assign out_chan.status    = s3_status_r;

endmodule

`default_nettype wire

// ===== design/sat_status.sv =====
// ----------------------------------------------------------------------------
// sat_status
// Present and limit decision for protected and long mode accesses.
// ----------------------------------------------------------------------------
`default_nettype none

module sat_status (
  input  wire sat_pkg::sat_chk_t chk,
  output sat_pkg::status_t       status
);
  import sat_pkg::*;

  always_comb begin
    status = ST_OK;
    if (!chk.present) begin
      status = ST_NOT_PRESENT;
    end else if (chk.check) begin
      if (chk.expand_down) begin
        // expand-down: valid range lies above the limit
        if ((!chk.gran && chk.off_gt_word) || !chk.off_gt_limit) begin
          status = ST_BOUNDS;
        end
      end else if (chk.off_gt_limit) begin
        status = ST_BOUNDS;
      end
    end
  end

endmodule

`default_nettype wire
